// ===== design/rmqt_pkg.sv =====
// shared types and constants for the range minimum query tree
`timescale 1ns / 1ps

package rmqt_pkg;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 10;
    localparam int COUNT_W = 11;
    localparam int ADDR_W  = 3;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam int MAX_ELEMENTS_DEFAULT = 1024;
    localparam int COUNT_RESET_VALUE    = 1024;

    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_ELEMENT_COUNT = 1'b0;

    typedef struct packed {
        logic                     action;
        logic [IDX_W-1:0]         load_index;
        logic signed [DATA_W-1:0] load_value;
        logic [IDX_W-1:0]         query_low;
        logic [IDX_W-1:0]         query_high;
    } rmqt_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] minimum;
        logic                     range_error;
    } rmqt_result_t;

endpackage

// ===== design/rmqt_engine.sv =====
// tree memory with its sequencer: leaf update walk and range walk
`timescale 1ns / 1ps

module rmqt_engine
    import rmqt_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] element_count,
    input  logic               item_valid,
    output logic               item_ready,
    input  rmqt_item_t         item,
    output logic               res_valid,
    input  logic               res_ready,
    output rmqt_result_t       res
);

    localparam int DEPTH  = 2 * MAX_ELEMENTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int NODE_W = AW + 1;
    localparam int CMP_W  = (NODE_W > COUNT_W) ? NODE_W : COUNT_W;

    localparam logic [AW-1:0]    LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [AW-1:0]    ROOT      = AW'(1);
    localparam logic [AW-1:0]    SIB_MASK  = AW'(1);
    localparam logic [CMP_W-1:0] LEAF_BASE = CMP_W'(MAX_ELEMENTS);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOAD  = 5'b00100,
        S_WALK  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_a_reg, rdata_b_reg;

    logic [AW-1:0]            clr_reg, clr_next;
    logic [AW-1:0]            k_reg, k_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [NODE_W-1:0]        l_reg, l_next;
    logic [NODE_W-1:0]        r_reg, r_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic                     err_reg, err_next;
    logic                     rda_vld_reg, rda_vld_next;
    logic                     rdb_vld_reg, rdb_vld_next;

    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [AW-1:0]            raddr_a, raddr_b;

    logic [CMP_W-1:0]         load_idx_ext, leaf_ext, lo_ext, hi_ext, l_init, r_init;
    logic [AW-1:0]            leaf, parent;
    logic                     load_skip, query_bad;
    logic [NODE_W-1:0]        l_inc, r_dec;
    logic signed [DATA_W-1:0] fold_ld, fold_a, fold_q;

    // index arithmetic in a width that holds both the port fields and the node numbers
    assign load_idx_ext = {{(CMP_W-IDX_W){1'b0}}, item.load_index};
    assign lo_ext       = {{(CMP_W-IDX_W){1'b0}}, item.query_low};
    assign hi_ext       = {{(CMP_W-IDX_W){1'b0}}, item.query_high};
    assign leaf_ext     = load_idx_ext + LEAF_BASE;
    assign l_init       = lo_ext + LEAF_BASE;
    assign r_init       = hi_ext + LEAF_BASE + CMP_W'(1);
    assign leaf         = leaf_ext[AW-1:0];
    assign parent       = k_reg >> 1;

    assign load_skip = (load_idx_ext >= LEAF_BASE);
    assign query_bad = (item.query_low > item.query_high) ||
                       ({1'b0, item.query_high} >= element_count);

    assign l_inc = l_reg + {{(NODE_W-1){1'b0}}, l_reg[0]};
    assign r_dec = r_reg - NODE_W'(1);

    assign fold_ld = (rdata_a_reg < val_reg) ? rdata_a_reg : val_reg;
    assign fold_a  = (rda_vld_reg && (rdata_a_reg < acc_reg)) ? rdata_a_reg : acc_reg;
    assign fold_q  = (rdb_vld_reg && (rdata_b_reg < fold_a)) ? rdata_b_reg : fold_a;

    assign item_ready      = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_DONE);
    assign res.minimum     = acc_reg;
    assign res.range_error = err_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        k_next       = k_reg;
        val_next     = val_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        acc_next     = acc_reg;
        err_next     = err_reg;
        rda_vld_next = 1'b0;
        rdb_vld_next = 1'b0;
        we           = 1'b0;
        waddr        = clr_reg;
        wdata        = INT_MAX;
        raddr_a      = l_reg[AW-1:0];
        raddr_b      = r_dec[AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.action == ACT_LOAD)
                    begin
                        if (!load_skip)
                        begin
                            // write the leaf and fetch its sibling in the same cycle
                            we         = 1'b1;
                            waddr      = leaf;
                            wdata      = item.load_value;
                            raddr_a    = leaf ^ SIB_MASK;
                            k_next     = leaf;
                            val_next   = item.load_value;
                            state_next = S_LOAD;
                        end
                    end
                    else
                    begin
                        acc_next = INT_MAX;
                        if (query_bad)
                        begin
                            err_next   = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            err_next   = 1'b0;
                            l_next     = l_init[NODE_W-1:0];
                            r_next     = r_init[NODE_W-1:0];
                            state_next = S_WALK;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                // one ancestor per cycle, sibling read issued alongside the write
                we       = 1'b1;
                waddr    = parent;
                wdata    = fold_ld;
                val_next = fold_ld;
                k_next   = parent;
                raddr_a  = parent ^ SIB_MASK;
                if (parent == ROOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                // fold reads issued last cycle, issue this level's reads
                acc_next = fold_q;
                if (l_reg < r_reg)
                begin
                    rda_vld_next = l_reg[0];
                    rdb_vld_next = r_reg[0];
                    l_next       = l_inc >> 1;
                    r_next       = (r_reg[0] ? r_dec : r_reg) >> 1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            rda_vld_reg <= 1'b0;
            rdb_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            rda_vld_reg <= rda_vld_next;
            rdb_vld_reg <= rdb_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        val_reg <= val_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        acc_reg <= acc_next;
        err_reg <= err_next;
    end

endmodule

// ===== design/range_minimum_query_tree_unit.sv =====
// range minimum query tree: config registers, tree engine and output register
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   action, load_index, load_value,
//                                                query_low, query_high
//   rsp       out        rsp_valid / rsp_ready   minimum, range_error
//   apb       in         psel / penable / pready element_count at byte address 0
//
// a load writes the leaf, then climbs one tree level a cycle on the single write
// port up to the root; an ignored load (index at or beyond MAX_ELEMENTS) writes nothing
// a query walks one level a cycle on the two read ports; a range error goes straight
// to the result without a walk
// after reset a clearing pass over every tree slot fills the tree before req_ready rises
// a finished result sits in the output register, so a new item is taken while it waits
`timescale 1ns / 1ps

module range_minimum_query_tree_unit
    import rmqt_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic                     action,
    input  logic [IDX_W-1:0]         load_index,
    input  logic signed [DATA_W-1:0] load_value,
    input  logic [IDX_W-1:0]         query_low,
    input  logic [IDX_W-1:0]         query_high,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic signed [DATA_W-1:0] minimum,
    output logic                     range_error,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_ELEMENTS > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(MAX_ELEMENTS);
    localparam logic [COUNT_W-1:0] COUNT_RESET =
        (MAX_ELEMENTS < COUNT_RESET_VALUE) ? COUNT_W'(MAX_ELEMENTS)
                                           : COUNT_W'(COUNT_RESET_VALUE);

    logic [COUNT_W-1:0]       element_count_reg;
    logic [COUNT_W-1:0]       wr_count;
    logic                     cfg_write;
    logic [REG_IDX_W-1:0]     reg_idx;

    rmqt_item_t               item;
    rmqt_result_t             res;
    logic                     res_valid, res_ready;

    logic                     rsp_valid_reg;
    logic signed [DATA_W-1:0] minimum_reg;
    logic                     range_error_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign wr_count  = (pwdata[COUNT_W-1:0] > COUNT_CAP) ? COUNT_CAP : pwdata[COUNT_W-1:0];
    assign prdata    = (reg_idx == REG_ELEMENT_COUNT)
                       ? {{(DATA_W-COUNT_W){1'b0}}, element_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= COUNT_RESET;
        end
        else if (cfg_write && (reg_idx == REG_ELEMENT_COUNT))
        begin
            element_count_reg <= wr_count;
        end
    end

    assign item.action     = action;
    assign item.load_index = load_index;
    assign item.load_value = load_value;
    assign item.query_low  = query_low;
    assign item.query_high = query_high;

    rmqt_engine #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_count (element_count_reg),
        .item_valid    (req_valid),
        .item_ready    (req_ready),
        .item          (item),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // output register takes a result when empty or being drained this cycle
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            minimum_reg     <= res.minimum;
            range_error_reg <= res.range_error;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign minimum     = minimum_reg;
    assign range_error = range_error_reg;

    a_error_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && range_error) |-> (minimum == INT_MAX))
        else $error("range error transfer without largest value");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        element_count_reg <= COUNT_CAP)
        else $error("element count above tree size");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (action == ACT_QUERY)) |=> !req_ready)
        else $error("ready right after a query transfer");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (action == ACT_LOAD)
         && ({{(32-IDX_W){1'b0}}, load_index} < 32'(MAX_ELEMENTS))) |=> !req_ready)
        else $error("ready right after a load transfer");

endmodule

// ===== test/tb.sv =====
// testbench for the range minimum query tree: own min-tree predictor, random handshakes
`timescale 1ns / 1ps

module tb
    import rmqt_pkg::*;
();

    localparam int MAX_N       = MAX_ELEMENTS_DEFAULT;
    localparam int SETTLE      = 40;
    localparam int STALL_LIMIT = 20000;
    localparam logic [ADDR_W-1:0] COUNT_ADDR = {REG_ELEMENT_COUNT, 2'b00};

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_ready;
    logic                     action = ACT_LOAD;
    logic [IDX_W-1:0]         load_index = '0;
    logic signed [DATA_W-1:0] load_value = '0;
    logic [IDX_W-1:0]         query_low = '0;
    logic [IDX_W-1:0]         query_high = '0;
    logic                     rsp_valid;
    logic                     rsp_ready = 1'b0;
    logic signed [DATA_W-1:0] minimum;
    logic                     range_error;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    // predictor state
    logic signed [DATA_W-1:0] tree_mins [1:2*MAX_N-1];
    int unsigned              visible_count = COUNT_RESET_VALUE;
    rmqt_result_t             pending_minima [$];

    int unsigned mismatches = 0;
    int unsigned idle_run = 0;
    int unsigned rsp_hold = 0;
    bit          no_idle = 1'b0;

    range_minimum_query_tree_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .action      (action),
        .load_index  (load_index),
        .load_value  (load_value),
        .query_low   (query_low),
        .query_high  (query_high),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .minimum     (minimum),
        .range_error (range_error),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [DATA_W-1:0] smaller(logic signed [DATA_W-1:0] a,
                                                         logic signed [DATA_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic void tree_store(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] val);
        int unsigned k;
        k = idx + MAX_N;
        tree_mins[k] = val;
        while (k > 1)
        begin
            k = k >> 1;
            tree_mins[k] = smaller(tree_mins[2*k], tree_mins[2*k+1]);
        end
    endfunction

    // bottom-up walk over the nodes that exactly cover lo..hi
    function automatic logic signed [DATA_W-1:0] tree_range_min(int unsigned lo, int unsigned hi);
        logic signed [DATA_W-1:0] m;
        int unsigned l;
        int unsigned r;
        m = INT_MAX;
        l = lo + MAX_N;
        r = hi + MAX_N + 1;
        while (l < r)
        begin
            if (l % 2 == 1)
            begin
                m = smaller(m, tree_mins[l]);
                l++;
            end
            if (r % 2 == 1)
            begin
                r--;
                m = smaller(m, tree_mins[r]);
            end
            l = l >> 1;
            r = r >> 1;
        end
        return m;
    endfunction

    function automatic void predict_item(rmqt_item_t it);
        rmqt_result_t res;
        if (it.action == ACT_LOAD)
            tree_store(it.load_index, it.load_value);
        else
        begin
            if (it.query_low > it.query_high || it.query_high >= visible_count)
            begin
                res.minimum     = INT_MAX;
                res.range_error = 1'b1;
            end
            else
            begin
                res.minimum     = tree_range_min(32'(it.query_low), 32'(it.query_high));
                res.range_error = 1'b0;
            end
            pending_minima.push_back(res);
        end
    endfunction

    function automatic void note_mismatch(string what, logic [DATA_W-1:0] want,
                                          logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch, %s at %0t: expected %0d, got %0d",
                     what, $time, $signed(want), $signed(got));
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0: return INT_MAX;
            1: return 32'sh8000_0000;
            2: return '0;
            3, 4, 5: return $signed($urandom_range(200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic rmqt_item_t load_item(int unsigned idx, logic signed [DATA_W-1:0] val);
        rmqt_item_t it;
        it.action     = ACT_LOAD;
        it.load_index = IDX_W'(idx);
        it.load_value = val;
        it.query_low  = IDX_W'($urandom);
        it.query_high = IDX_W'($urandom);
        return it;
    endfunction

    function automatic rmqt_item_t query_item(int unsigned lo, int unsigned hi);
        rmqt_item_t it;
        it.action     = ACT_QUERY;
        it.load_index = IDX_W'($urandom);
        it.load_value = $urandom;
        it.query_low  = IDX_W'(lo);
        it.query_high = IDX_W'(hi);
        return it;
    endfunction

    function automatic rmqt_item_t random_item(int unsigned load_pct);
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        pick = $urandom_range(99);
        if ($urandom_range(99) < load_pct)
        begin
            if (visible_count > 0 && pick < 85)
                return load_item($urandom_range(visible_count - 1), random_value());
            return load_item($urandom_range(MAX_N - 1), random_value());
        end
        if (visible_count > 0 && pick < 70)
        begin
            hi = $urandom_range(visible_count - 1);
            // narrow windows keep the walk near the leaves
            lo = (pick < 30) ? hi - $urandom_range(hi < 8 ? hi : 8) : $urandom_range(hi);
            return query_item(lo, hi);
        end
        if (pick < 80)
        begin
            hi = $urandom_range(MAX_N - 2);
            return query_item($urandom_range(MAX_N - 1, hi + 1), hi);
        end
        if (pick < 90 && visible_count < MAX_N)
        begin
            hi = $urandom_range(MAX_N - 1, visible_count);
            return query_item($urandom_range(hi), hi);
        end
        return query_item($urandom_range(MAX_N - 1), $urandom_range(MAX_N - 1));
    endfunction

    task automatic send_item(rmqt_item_t it);
        while (!no_idle && $urandom_range(99) < 7)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        action     <= it.action;
        load_index <= it.load_index;
        load_value <= it.load_value;
        query_low  <= it.query_low;
        query_high <= it.query_high;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_item(it);
    endtask

    // loads give no result, so let the last one finish its climb too
    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_minima.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_element_count(logic [DATA_W-1:0] data);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        visible_count = (data[COUNT_W-1:0] > MAX_N) ? MAX_N : data[COUNT_W-1:0];
    endtask

    task automatic run_random(int unsigned n, int unsigned load_pct);
        repeat (n) send_item(random_item(load_pct));
    endtask

    task automatic test_directed();
        send_item(query_item(0, MAX_N - 1));
        send_item(load_item(0, 32'sh8000_0000));
        send_item(load_item(MAX_N - 1, INT_MAX));
        send_item(load_item(512, -1));
        send_item(load_item(511, 0));
        send_item(load_item(MAX_N - 2, 32'sh8000_0001));
        send_item(query_item(0, 0));
        send_item(query_item(MAX_N - 1, MAX_N - 1));
        send_item(query_item(1, MAX_N - 1));
        send_item(query_item(511, 512));
        send_item(query_item(5, 4));
        send_item(query_item(MAX_N - 1, 0));
        send_item(query_item(0, MAX_N - 1));
        write_element_count(10);
        send_item(query_item(0, 10));
        send_item(query_item(0, 9));
        // stored beyond the count, hidden until it grows
        send_item(load_item(20, -5));
        send_item(query_item(9, 20));
        write_element_count(2047);
        send_item(query_item(13, MAX_N - 3));
        write_element_count(0);
        send_item(query_item(0, 0));
        write_element_count(1);
        send_item(query_item(0, 0));
        send_item(query_item(0, 1));
        // upper data bits lie outside the register
        write_element_count(32'hFFFF_F805);
        send_item(query_item(0, 4));
        send_item(query_item(0, 5));
    endtask

    task automatic test_full_range();
        write_element_count(MAX_N);
        run_random(500, 50);
    endtask

    task automatic test_short_counts();
        repeat (3)
        begin
            write_element_count($urandom_range(2, 40));
            run_random(100, 40);
        end
    endtask

    task automatic test_single_element();
        write_element_count(1);
        run_random(80, 40);
    endtask

    task automatic test_steady_stream();
        write_element_count(MAX_N);
        no_idle = 1'b1;
        run_random(300, 50);
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        rsp_hold = 300;
        run_random(60, 20);
    endtask

    task automatic test_mixed_counts();
        repeat (4)
        begin
            write_element_count($urandom_range(1, MAX_N));
            run_random(150, 45);
        end
    endtask

    always @(posedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp_ready <= 1'b0;
            rsp_hold--;
        end
        else
            rsp_ready <= no_idle || ($urandom_range(99) >= 7);
    end

    always @(posedge clk)
    begin
        rmqt_result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_minima.size() == 0)
                note_mismatch("result with none pending", INT_MAX, minimum);
            else
            begin
                want = pending_minima.pop_front();
                if (want.minimum !== minimum)
                    note_mismatch("minimum", want.minimum, minimum);
                if (want.range_error !== range_error)
                    note_mismatch("range_error", DATA_W'(want.range_error),
                                  DATA_W'(range_error));
            end
        end
    end

    // the clearing pass after reset is well inside the limit
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            idle_run = 0;
        else
        begin
            idle_run++;
            if (idle_run >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int k = 1; k < 2 * MAX_N; k++)
            tree_mins[k] = INT_MAX;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_range();
        test_short_counts();
        test_single_element();
        test_steady_stream();
        test_output_stall();
        test_mixed_counts();
        drain_results();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
